// ----- hw/rtl/keypad_setpoint_threshold_alarm_unit_defines.svh -----
// assertion macros shared by the keypad setpoint threshold alarm unit
`ifndef KEYPAD_SETPOINT_THRESHOLD_ALARM_UNIT_DEFINES_SVH
`define KEYPAD_SETPOINT_THRESHOLD_ALARM_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define KPTA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define KPTA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KPTA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define KPTA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/kpta_pkg.sv -----
// types, constants and helper functions of the keypad setpoint threshold alarm unit
package kpta_pkg;

    // sizing
    localparam int MAX_DIGITS   = 4;
    localparam int ADC_BITS     = 12;
    localparam int SHORT_DIGITS = (MAX_DIGITS < 3) ? MAX_DIGITS : 3;
    localparam int IDX_W        = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int DCNT_W       = 3;
    localparam int VAL_W        = 14;
    localparam int TV_W         = 8;
    localparam int HV_W         = 7;
    localparam int LV_W         = 10;
    localparam int SCL_W        = 10;
    localparam int GAIN_W       = 10;
    localparam int PROD_W       = ADC_BITS + GAIN_W;

    localparam logic [VAL_W-1:0]  LIMIT_MAX  = 14'd16383;
    localparam logic [GAIN_W-1:0] GAIN_TEMP  = 10'd150;
    localparam logic [GAIN_W-1:0] GAIN_HUMID = 10'd100;
    localparam logic [GAIN_W-1:0] GAIN_LIGHT = 10'd1000;

    // key codes
    localparam logic [7:0] KEY_STAR = 8'h2A;
    localparam logic [7:0] KEY_HASH = 8'h23;
    localparam logic [7:0] KEY_A    = 8'h41;
    localparam logic [7:0] KEY_B    = 8'h42;
    localparam logic [7:0] KEY_C    = 8'h43;
    localparam logic [7:0] KEY_D    = 8'h44;
    localparam logic [7:0] KEY_0    = 8'h30;
    localparam logic [7:0] KEY_9    = 8'h39;

    typedef enum logic {
        OP_KEY    = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        KA_IGNORED = 3'd0,
        KA_EXIT    = 3'd1,
        KA_SELECT  = 3'd2,
        KA_SAVE    = 3'd3,
        KA_ERASE   = 3'd4,
        KA_DIGIT   = 3'd5
    } key_action_t;

    typedef enum logic [1:0] {
        TGT_NONE  = 2'd0,
        TGT_TEMP  = 2'd1,
        TGT_HUMID = 2'd2,
        TGT_LIGHT = 2'd3
    } target_t;

    typedef enum logic [1:0] {
        AK_NONE  = 2'd0,
        AK_TEMP  = 2'd1,
        AK_HUMID = 2'd2,
        AK_LIGHT = 2'd3
    } alarm_kind_t;

    typedef enum logic [1:0] {
        SCR_NONE     = 2'd0,
        SCR_ANNOUNCE = 2'd1,
        SCR_RESTORE  = 2'd2
    } screen_t;

    typedef logic [3:0] digit_t;
    typedef digit_t [MAX_DIGITS-1:0] digit_row_t;

    // keypad entry result
    typedef struct packed {
        logic              mode;
        key_action_t       action;
        target_t           target;
        logic [DCNT_W-1:0] count;
        logic [VAL_W-1:0]  value;
    } entry_res_t;

    // mode and stored limits seen by the monitor
    typedef struct packed {
        logic             mode;
        logic [VAL_W-1:0] t_lim;
        logic [VAL_W-1:0] h_lim;
        logic [VAL_W-1:0] l_lim;
    } setup_t;

    // monitor result
    typedef struct packed {
        alarm_kind_t     kind;
        screen_t         screen;
        logic            shown;
        logic [TV_W-1:0] tv;
        logic [HV_W-1:0] hv;
        logic [LV_W-1:0] lv;
    } mon_res_t;

    // decimal value of the first n digits, saturating
    function automatic logic [VAL_W-1:0] digits_value(digit_row_t d, logic [DCNT_W-1:0] n);
        logic [VAL_W-1:0] v;
        logic [VAL_W+3:0] t;
        v = '0;
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{VAL_W{1'b0}}, d[k]};
            if (DCNT_W'(k) < n)
            begin
                v = (t > {4'b0, LIMIT_MAX}) ? LIMIT_MAX : t[VAL_W-1:0];
            end
        end
        return v;
    endfunction

    // floor(raw * gain / (2^ADC_BITS - 1)) without a divider:
    // x / (2^k - 1) == (x + (x >> k) + 1) >> k for x below 2^(2k) - 1
    function automatic logic [SCL_W-1:0] scale_adc(logic [ADC_BITS-1:0] raw,
                                                   logic [GAIN_W-1:0] gain);
        logic [PROD_W-1:0] prod;
        logic [PROD_W:0]   sum;
        prod = PROD_W'(raw) * PROD_W'(gain);
        sum  = {1'b0, prod} + {1'b0, (prod >> ADC_BITS)} + (PROD_W+1)'(1);
        return SCL_W'(sum >> ADC_BITS);
    endfunction

endpackage

// ----- hw/rtl/kpta_ifs.sv -----
// command and result channel interfaces
interface kpta_cmd_if
    import kpta_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                op;
    logic [7:0]          key_char;
    logic [ADC_BITS-1:0] adc_temperature;
    logic [ADC_BITS-1:0] adc_humidity;
    logic [ADC_BITS-1:0] adc_light;

    modport source (
        output valid, op, key_char, adc_temperature, adc_humidity, adc_light,
        input  ready
    );
    modport sink (
        input  valid, op, key_char, adc_temperature, adc_humidity, adc_light,
        output ready
    );
endinterface

interface kpta_rsp_if
    import kpta_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              in_entry_mode;
    logic [2:0]        key_action;
    logic [1:0]        entry_target;
    logic [DCNT_W-1:0] digit_count;
    logic [VAL_W-1:0]  entry_value;
    logic [1:0]        alarm_kind;
    logic [1:0]        screen_event;
    logic              values_shown;
    logic [TV_W-1:0]   temperature_value;
    logic [HV_W-1:0]   humidity_value;
    logic [LV_W-1:0]   light_value;

    modport source (
        output valid, in_entry_mode, key_action, entry_target, digit_count, entry_value,
               alarm_kind, screen_event, values_shown, temperature_value,
               humidity_value, light_value,
        input  ready
    );
    modport sink (
        input  valid, in_entry_mode, key_action, entry_target, digit_count, entry_value,
               alarm_kind, screen_event, values_shown, temperature_value,
               humidity_value, light_value,
        output ready
    );
endinterface

// ----- hw/rtl/kpta_entry.sv -----
// keypad limit entry: mode, target, digit store and stored limits
module kpta_entry
    import kpta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       op,
    input  logic [7:0] key_char,
    output entry_res_t res,
    output setup_t     setup
);

    logic              mode_reg,   mode_next;
    target_t           target_reg, target_next;
    logic [DCNT_W-1:0] dlim_reg,   dlim_next;
    digit_row_t        store_reg,  store_next;
    logic [DCNT_W-1:0] held_reg,   held_next;
    logic [VAL_W-1:0]  tlim_reg,   tlim_next;
    logic [VAL_W-1:0]  hlim_reg,   hlim_next;
    logic [VAL_W-1:0]  llim_reg,   llim_next;
    key_action_t       action;
    logic [VAL_W-1:0]  held_value;
    logic [7:0]        digit_code;

    assign held_value = digits_value(store_reg, held_reg);
    assign digit_code = key_char - KEY_0;

    // key decode and next state
    always_comb
    begin
        mode_next   = mode_reg;
        target_next = target_reg;
        dlim_next   = dlim_reg;
        store_next  = store_reg;
        held_next   = held_reg;
        tlim_next   = tlim_reg;
        hlim_next   = hlim_reg;
        llim_next   = llim_reg;
        action      = KA_IGNORED;
        if (mode_reg && (op == OP_KEY))
        begin
            case (key_char)
                KEY_STAR:
                begin
                    mode_next = 1'b0;
                    action    = KA_EXIT;
                end
                KEY_A, KEY_B, KEY_C:
                begin
                    target_next = (key_char == KEY_A) ? TGT_TEMP :
                                  (key_char == KEY_B) ? TGT_HUMID : TGT_LIGHT;
                    dlim_next   = (key_char == KEY_C) ? DCNT_W'(MAX_DIGITS)
                                                      : DCNT_W'(SHORT_DIGITS);
                    held_next   = '0;
                    action      = KA_SELECT;
                end
                KEY_HASH:
                begin
                    case (target_reg)
                        TGT_TEMP:  tlim_next = held_value;
                        TGT_HUMID: hlim_next = held_value;
                        TGT_LIGHT: llim_next = held_value;
                        default:   ;
                    endcase
                    if (target_reg != TGT_NONE)
                    begin
                        action = KA_SAVE;
                    end
                end
                KEY_D:
                begin
                    if (held_reg != '0)
                    begin
                        held_next = held_reg - DCNT_W'(1);
                        store_next[held_next[IDX_W-1:0]] = '0;
                        action = KA_ERASE;
                    end
                end
                default:
                begin
                    if ((key_char >= KEY_0) && (key_char <= KEY_9) &&
                        (held_reg < dlim_reg) && (held_reg < DCNT_W'(MAX_DIGITS)))
                    begin
                        store_next[held_reg[IDX_W-1:0]] = digit_code[3:0];
                        held_next = held_reg + DCNT_W'(1);
                        action    = KA_DIGIT;
                    end
                end
            endcase
            // empty store reads as all zero
            if (held_next == '0)
            begin
                store_next = '0;
            end
        end
    end

    // entry state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            target_reg <= TGT_NONE;
            dlim_reg   <= DCNT_W'(SHORT_DIGITS);
            store_reg  <= '0;
            held_reg   <= '0;
            tlim_reg   <= '0;
            hlim_reg   <= '0;
            llim_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            target_reg <= target_next;
            dlim_reg   <= dlim_next;
            store_reg  <= store_next;
            held_reg   <= held_next;
            tlim_reg   <= tlim_next;
            hlim_reg   <= hlim_next;
            llim_reg   <= llim_next;
        end
    end

    // result after this transaction
    always_comb
    begin
        res.mode   = mode_next;
        res.action = action;
        res.target = target_next;
        res.count  = held_next;
        res.value  = digits_value(store_next, held_next);
    end

    // current mode and limits
    always_comb
    begin
        setup.mode  = mode_reg;
        setup.t_lim = tlim_reg;
        setup.h_lim = hlim_reg;
        setup.l_lim = llim_reg;
    end

endmodule

// ----- hw/rtl/kpta_monitor.sv -----
// threshold checks and alarm screen tracking
module kpta_monitor
    import kpta_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            op,
    input  setup_t          setup,
    input  logic [TV_W-1:0] tv,
    input  logic [HV_W-1:0] hv,
    input  logic [LV_W-1:0] lv,
    output mon_res_t        res
);

    logic        active_reg,    active_next;
    logic        announced_reg, announced_next;
    logic        sample;
    alarm_kind_t kind;

    assign sample = !setup.mode && (op == OP_SAMPLE);

    // first limit exceeded, temperature first
    always_comb
    begin
        if ({{(VAL_W-TV_W){1'b0}}, tv} > setup.t_lim)
        begin
            kind = AK_TEMP;
        end
        else if ({{(VAL_W-HV_W){1'b0}}, hv} > setup.h_lim)
        begin
            kind = AK_HUMID;
        end
        else if ({{(VAL_W-LV_W){1'b0}}, lv} > setup.l_lim)
        begin
            kind = AK_LIGHT;
        end
        else
        begin
            kind = AK_NONE;
        end
    end

    // alarm state and screen events
    always_comb
    begin
        active_next    = active_reg;
        announced_next = announced_reg;
        res.kind       = AK_NONE;
        res.screen     = SCR_NONE;
        res.shown      = 1'b0;
        res.tv         = '0;
        res.hv         = '0;
        res.lv         = '0;
        if (sample)
        begin
            res.kind = kind;
            res.tv   = tv;
            res.hv   = hv;
            res.lv   = lv;
            if (kind != AK_NONE)
            begin
                active_next = 1'b1;
                if (!announced_reg)
                begin
                    res.screen     = SCR_ANNOUNCE;
                    announced_next = 1'b1;
                end
            end
            else
            begin
                if (active_reg)
                begin
                    res.screen     = SCR_RESTORE;
                    announced_next = 1'b0;
                    active_next    = 1'b0;
                end
                res.shown = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            announced_reg <= 1'b0;
        end
        else if (step)
        begin
            active_reg    <= active_next;
            announced_reg <= announced_next;
        end
    end

endmodule

// ----- hw/rtl/keypad_setpoint_threshold_alarm_unit.sv -----
// top level: keypad setpoint entry and three-channel threshold alarm
//
//   channel  dir  carries
//   -------  ---  -----------------------------------------------------------
//   cmd      in   op, key_char, adc_temperature, adc_humidity, adc_light
//   rsp      out  mode, key action, target, digits, value, alarm, screen, values
//
// one transaction per cycle sustained while results are taken; a result is
// valid once its command has passed the input register, where scaling lands
// as it is taken, and the result register, where entry and alarm logic land.
// every command gives exactly one result.
// reset returns to entry mode and clears the digit store, limits and alarm flags.
// a stalled result holds the result register; the input register still takes
// one more command, and both stall together after that.
`include "keypad_setpoint_threshold_alarm_unit_defines.svh"

module keypad_setpoint_threshold_alarm_unit
    import kpta_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    kpta_cmd_if.sink      cmd,
    kpta_rsp_if.source    rsp
);

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_op_reg;
    logic [7:0]        s1_key_reg;
    logic [TV_W-1:0]   s1_tv_reg;
    logic [HV_W-1:0]   s1_hv_reg;
    logic [LV_W-1:0]   s1_lv_reg;
    logic              out_valid_reg, out_valid_next;
    entry_res_t        out_ent_reg;
    mon_res_t          out_mon_reg;
    logic              s1_adv;
    logic              step;
    logic              cmd_take;
    logic [SCL_W-1:0]  tv_scaled;
    logic [SCL_W-1:0]  hv_scaled;
    logic [SCL_W-1:0]  lv_scaled;
    entry_res_t        ent_res;
    setup_t            setup;
    mon_res_t          mon_res;

    // handshake
    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign step      = s1_valid_reg && s1_adv;
    assign cmd.ready = !s1_valid_reg || s1_adv;
    assign cmd_take  = cmd.valid && cmd.ready;

    // scaling ahead of the input register
    assign tv_scaled = scale_adc(cmd.adc_temperature, GAIN_TEMP);
    assign hv_scaled = scale_adc(cmd.adc_humidity, GAIN_HUMID);
    assign lv_scaled = scale_adc(cmd.adc_light, GAIN_LIGHT);

    assign s1_valid_next  = cmd_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = step ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_op_reg  <= cmd.op;
            s1_key_reg <= cmd.key_char;
            s1_tv_reg  <= tv_scaled[TV_W-1:0];
            s1_hv_reg  <= hv_scaled[HV_W-1:0];
            s1_lv_reg  <= lv_scaled[LV_W-1:0];
        end
    end

    kpta_entry u_entry (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .op       (s1_op_reg),
        .key_char (s1_key_reg),
        .res      (ent_res),
        .setup    (setup)
    );

    kpta_monitor u_monitor (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .op    (s1_op_reg),
        .setup (setup),
        .tv    (s1_tv_reg),
        .hv    (s1_hv_reg),
        .lv    (s1_lv_reg),
        .res   (mon_res)
    );

    // result register payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_ent_reg <= ent_res;
            out_mon_reg <= mon_res;
        end
    end

    // result channel
    assign rsp.valid             = out_valid_reg;
    assign rsp.in_entry_mode     = out_ent_reg.mode;
    assign rsp.key_action        = out_ent_reg.action;
    assign rsp.entry_target      = out_ent_reg.target;
    assign rsp.digit_count       = out_ent_reg.count;
    assign rsp.entry_value       = out_ent_reg.value;
    assign rsp.alarm_kind        = out_mon_reg.kind;
    assign rsp.screen_event      = out_mon_reg.screen;
    assign rsp.values_shown      = out_mon_reg.shown;
    assign rsp.temperature_value = out_mon_reg.tv;
    assign rsp.humidity_value    = out_mon_reg.hv;
    assign rsp.light_value       = out_mon_reg.lv;

    // checks
    `KPTA_ASSERT_NXT(a_step_loads_result, clk, rst_n, step, out_valid_reg, "result register not loaded after a step")
    `KPTA_ASSERT_IMP(a_screen_only_monitor, clk, rst_n, out_valid_reg && (out_mon_reg.screen != SCR_NONE), !out_ent_reg.mode, "screen event reported in entry mode")
    `KPTA_ASSERT_IMP(a_shown_no_alarm, clk, rst_n, out_valid_reg && out_mon_reg.shown, out_mon_reg.kind == AK_NONE, "values shown while an alarm fires")
    `KPTA_ASSERT_IMP(a_digit_bound, clk, rst_n, out_valid_reg, out_ent_reg.count <= DCNT_W'(MAX_DIGITS), "digit count beyond the store")

endmodule
